[rtl/core/cv_shadow_merge_table_core_assert.svh]
// Assertion macros for the shadow merge table core.
// Used by files that include this header; expects clk_i and rst_ni in scope.
`ifndef CV_SHADOW_MERGE_TABLE_CORE_ASSERT_SVH
`define CV_SHADOW_MERGE_TABLE_CORE_ASSERT_SVH

// same-cycle implication
`define SMT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SMT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/smt_pkg.sv]
// Shared types and constants for the shadow merge table core.
// No dependencies.
package smt_pkg;

  localparam int unsigned SMT_ENTRY_COUNT  = 1024;
  localparam int unsigned SMT_FIRST_NUMBER = 1;

  typedef enum logic [2:0] {
    OP_CLEAR       = 3'd0,
    OP_MERGE_READ  = 3'd1,
    OP_BASE_READ   = 3'd2,
    OP_FINAL_READ  = 3'd3,
    OP_FINAL_WRITE = 3'd4,
    OP_DELTA       = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_INVALID   = 2'd1,
    ST_OVERWRITE = 2'd2
  } status_e;

  // one table word: pending value, pending mask, known value, known mask
  typedef struct packed {
    logic [7:0] pv;
    logic [7:0] pm;
    logic [7:0] kv;
    logic [7:0] km;
  } entry_t;

  typedef struct packed {
    status_e    status;
    logic [7:0] mask_out;
    logic [7:0] value_out;
    logic       wr_en;
    entry_t     wr_data;
  } alu_res_t;

endpackage

[rtl/core/smt_ram.sv]
// Simple dual-port synchronous RAM with registered read.
// Depends on nothing.
module smt_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10,
  parameter int unsigned W     = 32
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [W-1:0]  rdata_o
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

[rtl/core/smt_alu.sv]
// Command datapath: computes the result and the write-back word for one entry.
// Depends on smt_pkg.
module smt_alu (
  input  logic [2:0]        op_i,
  input  logic              in_range_i,
  input  logic [7:0]        bit_mask_i,
  input  logic [7:0]        data_byte_i,
  input  smt_pkg::entry_t   entry_i,
  output smt_pkg::alu_res_t res_o
);
  import smt_pkg::*;

  logic [7:0] delta;

  always_comb begin
    delta = entry_i.pm & (~entry_i.km | (entry_i.kv ^ entry_i.pv));
    res_o           = '0;
    res_o.status    = ST_OK;
    res_o.wr_data   = entry_i;
    if (op_i != OP_CLEAR && op_i <= OP_DELTA && !in_range_i) begin
      res_o.status = ST_INVALID;
    end else begin
      unique case (op_i)
        OP_MERGE_READ: begin
          // only touch the entry if some bit is still unknown
          if ((entry_i.km & bit_mask_i) != bit_mask_i) begin
            res_o.wr_en      = 1'b1;
            res_o.wr_data.kv = entry_i.kv | (data_byte_i & bit_mask_i);
            res_o.wr_data.km = entry_i.km | bit_mask_i;
          end
        end
        OP_BASE_READ: begin
          res_o.mask_out  = entry_i.km;
          res_o.value_out = entry_i.kv;
        end
        OP_FINAL_READ: begin
          res_o.mask_out  = entry_i.km | entry_i.pm;
          res_o.value_out = (entry_i.kv & ~entry_i.pm) | entry_i.pv;
        end
        OP_FINAL_WRITE: begin
          if ((entry_i.pm & bit_mask_i) != 8'h00) begin
            res_o.status = ST_OVERWRITE;
          end else begin
            res_o.wr_en      = 1'b1;
            res_o.wr_data.pv = entry_i.pv | (data_byte_i & bit_mask_i);
            res_o.wr_data.pm = entry_i.pm | bit_mask_i;
          end
        end
        OP_DELTA: begin
          res_o.mask_out  = delta;
          res_o.value_out = entry_i.pv & delta;
        end
        default: begin
          // clear (sweep already done) and unused codes: plain success
        end
      endcase
    end
  end

endmodule

[rtl/core/cv_shadow_merge_table_core.sv]
// Top level of the shadow merge table: sequencer, table RAM and datapath.
// Depends on smt_pkg, smt_ram, smt_alu and the assertion header.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------------
//  in      | request   | in_valid_i / in_ready_o | operation, cv_number, bit_mask, data
//  out     | response  | out_valid_o / out_ready_i | status, mask_out, value_out
//
// Each request reads the RAM on accept, then is modified and written back in S_EXEC,
// which stalls while the output register is full; the RAM's registered read sets this split.
// Clear sweeps the RAM one entry per cycle over all ENTRY_COUNT entries, then responds.
// After reset the same sweep runs in S_INIT with in_ready_o low.
// A response waits in the output register; the next request is taken meanwhile,
// and it stalls in its write-back cycle until the output register frees.
module cv_shadow_merge_table_core #(
  parameter int unsigned ENTRY_COUNT  = smt_pkg::SMT_ENTRY_COUNT,
  parameter int unsigned FIRST_NUMBER = smt_pkg::SMT_FIRST_NUMBER
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  operation_i,
  input  logic [11:0] cv_number_i,
  input  logic [7:0]  bit_mask_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [7:0]  mask_out_o,
  output logic [7:0]  value_out_o
);
  import smt_pkg::*;

  localparam int unsigned AW = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_INIT,
    S_CLEAR,
    S_EXEC
  } state_e;

  state_e        state_q;
  logic [AW-1:0] cnt_q;
  logic [2:0]    op_q;
  logic          range_q;
  logic [AW-1:0] idx_q;
  logic [7:0]    mask_q;
  logic [7:0]    data_q;
  logic          out_valid_q;
  logic [1:0]    status_q;
  logic [7:0]    mask_out_q;
  logic [7:0]    value_out_q;

  logic          out_valid_d;
  logic          in_accept;
  logic          in_range;
  logic [11:0]   idx_full;
  logic          sweep_last;
  logic          out_free;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [31:0]   mem_wdata;
  logic [31:0]   mem_rdata;
  alu_res_t      alu_res;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;
  assign in_range   = ({1'b0, cv_number_i} >= 13'(FIRST_NUMBER)) &&
                      ({1'b0, cv_number_i} < 13'(FIRST_NUMBER + ENTRY_COUNT));
  assign idx_full   = cv_number_i - 12'(FIRST_NUMBER);
  assign sweep_last = (cnt_q == AW'(ENTRY_COUNT - 1));
  assign out_free   = !out_valid_q || out_ready_i;
  assign out_valid_d = (state_q == S_EXEC && out_free) || (out_valid_q && !out_ready_i);

  smt_alu u_alu (
    .op_i       (op_q),
    .in_range_i (range_q),
    .bit_mask_i (mask_q),
    .data_byte_i(data_q),
    .entry_i    (entry_t'(mem_rdata)),
    .res_o      (alu_res)
  );

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_q;
    mem_wdata = alu_res.wr_data;
    unique case (state_q)
      S_INIT, S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q;
        mem_wdata = '0;
      end
      S_EXEC: begin
        mem_we = out_free && alu_res.wr_en;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  smt_ram #(
    .DEPTH(ENTRY_COUNT),
    .AW   (AW),
    .W    (32)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (in_accept && in_range),
    .raddr_i(idx_full[AW-1:0]),
    .rdata_o(mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      cnt_q       <= '0;
      op_q        <= OP_CLEAR;
      range_q     <= 1'b0;
      idx_q       <= '0;
      mask_q      <= '0;
      data_q      <= '0;
      out_valid_q <= 1'b0;
      status_q    <= ST_OK;
      mask_out_q  <= '0;
      value_out_q <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      unique case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            op_q    <= operation_i;
            range_q <= in_range;
            idx_q   <= idx_full[AW-1:0];
            mask_q  <= bit_mask_i;
            data_q  <= data_byte_i;
            cnt_q   <= '0;
            state_q <= (operation_i == OP_CLEAR) ? S_CLEAR : S_EXEC;
          end
        end
        S_INIT: begin
          cnt_q <= cnt_q + 1'b1;
          if (sweep_last) begin
            state_q <= S_IDLE;
          end
        end
        S_CLEAR: begin
          cnt_q <= cnt_q + 1'b1;
          if (sweep_last) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (out_free) begin
            status_q    <= alu_res.status;
            mask_out_q  <= alu_res.mask_out;
            value_out_q <= alu_res.value_out;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign mask_out_o  = mask_out_q;
  assign value_out_o = value_out_q;

`include "cv_shadow_merge_table_core_assert.svh"

  `SMT_ASSERT_IMPL(a_no_write_idle, state_q == S_IDLE, !mem_we, "RAM write while idle")
  `SMT_ASSERT_IMPL(a_invalid_no_write,
                   state_q == S_EXEC && !range_q && op_q != OP_CLEAR,
                   !alu_res.wr_en, "write on invalid number")
  `SMT_ASSERT_NEXT(a_accept_leaves_idle, in_accept,
                   state_q == S_EXEC || state_q == S_CLEAR, "request not started")
  `SMT_ASSERT_IMPL(a_exec_no_clobber,
                   state_q == S_EXEC && out_valid_q && !out_ready_i,
                   !mem_we, "write-back before response slot free")

endmodule
